/* hdl/swaf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the stopwatch ASCII formatter.
// No dependencies; every other file imports this package.
package swaf_pkg;

    // Display modes held by the front end and carried with every job.
    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_MMSS  = 2'd1,
        MODE_POINT = 2'd2,
        MODE_PLAIN = 2'd3
    } mode_t;

    // Command characters.
    localparam logic [7:0] CMD_MODE1 = 8'd49;
    localparam logic [7:0] CMD_MODE2 = 8'd50;
    localparam logic [7:0] CMD_MODE3 = 8'd51;
    localparam logic [7:0] CMD_STOP  = 8'd113;

    // Characters that the formatter emits.
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Field widths.
    localparam int COUNT_W = 20;
    localparam int DIGIT_W = 5;
    localparam int NUM_DIGITS = 6;

    // Reciprocal constants: x/10 = (x*DIV10_MULT) >> 23 for x below 2^22,
    // x/60 = (x*DIV60_MULT) >> 20 for x below 23831.
    localparam logic [COUNT_W-1:0] DIV10_MULT = 20'd838861;
    localparam logic [COUNT_W-1:0] DIV60_MULT = 20'd17477;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Input word: one command character or one refresh request.
    typedef struct packed {
        logic               action;
        logic [7:0]         rx_char;
        logic [COUNT_W-1:0] count_value;
    } in_word_t;

    // Output word: one character.
    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_word_t;

    // Refresh job queued by the front end.
    typedef struct packed {
        mode_t              mode;
        logic [COUNT_W-1:0] count;
    } job_t;

    // Converted job: mode and decimal digits, most significant first at index 5.
    typedef struct packed {
        mode_t                                mode;
        logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
    } fmt_t;

    // Valid/take pair between two internal stages.
    typedef struct packed {
        logic valid;
        logic take;
    } link_t;

endpackage

/* hdl/swaf_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input words, keeps the display mode and stop flag,
// and queues refresh jobs. Depends on swaf_pkg.
module swaf_front
    import swaf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  in_word_t req_word,
    output logic     q_push,
    output job_t     q_entry,
    input  logic     q_full
);

    mode_t mode_reg, mode_next;
    logic  stopped_reg, stopped_next;
    logic  accept;

    // Stall only while the job queue has no room.
    assign req_stall = q_full;
    assign accept    = req_valid && !req_stall;

    // Classify the accepted word.
    always_comb
    begin
        mode_next    = mode_reg;
        stopped_next = stopped_reg;
        q_push       = 1'b0;
        if (accept && !stopped_reg)
        begin
            if (!req_word.action)
            begin
                case (req_word.rx_char)
                    CMD_MODE1: mode_next    = MODE_MMSS;
                    CMD_MODE2: mode_next    = MODE_POINT;
                    CMD_MODE3: mode_next    = MODE_PLAIN;
                    CMD_STOP:  stopped_next = 1'b1;
                    default:   mode_next    = mode_reg;
                endcase
            end
            else if (mode_reg != MODE_OFF)
            begin
                q_push = 1'b1;
            end
        end
    end

    assign q_entry.mode  = mode_reg;
    assign q_entry.count = req_word.count_value;

    // Mode and stop flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_OFF;
            stopped_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

/* hdl/swaf_queue.sv */
`timescale 1ns / 1ps
// Short flip-flop queue of refresh jobs between front end and converter.
// Depends on swaf_pkg.
module swaf_queue
    import swaf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  job_t  push_entry,
    output logic  full,
    output link_t pop_link_out,
    input  logic  pop,
    output job_t  pop_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    assign full               = (fill_reg == CW'(DEPTH));
    assign pop_link_out.valid = (fill_reg != '0);
    assign pop_link_out.take  = pop;
    assign pop_entry          = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hdl/swaf_conv.sv */
`timescale 1ns / 1ps
// Converter: splits a count into decimal digits with one reciprocal
// multiply per cycle, five steps per job. Depends on swaf_pkg.
module swaf_conv
    import swaf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  link_t q_link,
    output logic  q_pop,
    input  job_t  q_entry,
    output link_t fmt_link,
    input  logic  fmt_take,
    output fmt_t  fmt
);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_BUSY = 3'b010,
        C_DONE = 3'b100
    } conv_state_t;

    localparam logic [2:0] LAST_STEP = 3'd4;

    conv_state_t        state_reg, state_next;
    logic [2:0]         step_reg, step_next;
    mode_t              mode_reg, mode_next;
    logic [COUNT_W-1:0] val_reg, val_next;
    logic [5:0]         aux_reg, aux_next;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] dig_reg, dig_next;

    logic               use60;
    logic [2*COUNT_W-1:0] prod;
    logic [COUNT_W-1:0] quo;
    logic [COUNT_W-1:0] quo_times;
    logic [COUNT_W-1:0] rem_wide;
    logic [5:0]         rem;

    // One divide step: by 60 for the seconds split, otherwise by 10.
    assign use60     = (mode_reg == MODE_MMSS) && (step_reg == 3'd2);
    assign prod      = val_reg * (use60 ? DIV60_MULT : DIV10_MULT);
    assign quo       = use60 ? prod[2*COUNT_W-1:COUNT_W] : {3'b000, prod[2*COUNT_W-1:23]};
    assign quo_times = use60 ? ((quo << 6) - (quo << 2)) : ((quo << 3) + (quo << 1));
    assign rem_wide  = val_reg - quo_times;
    assign rem       = rem_wide[5:0];

    // Take a new job when idle or when the finished one is handed on.
    assign q_pop = q_link.valid &&
                   ((state_reg == C_IDLE) || ((state_reg == C_DONE) && fmt_take));

    assign fmt_link.valid = (state_reg == C_DONE);
    assign fmt_link.take  = fmt_take;
    assign fmt.mode       = mode_reg;
    assign fmt.digits     = dig_reg;

    // Sequencer and digit datapath.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mode_next  = mode_reg;
        val_next   = val_reg;
        aux_next   = aux_reg;
        dig_next   = dig_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = C_BUSY;
                end
            end
            C_BUSY:
            begin
                step_next = step_reg + 1'b1;
                val_next  = quo;
                if (mode_reg == MODE_MMSS)
                begin
                    case (step_reg)
                        3'd2: aux_next = rem;
                        3'd3:
                        begin
                            dig_next[5] = quo[DIGIT_W-1:0];
                            dig_next[4] = rem[DIGIT_W-1:0];
                            val_next    = {{(COUNT_W-6){1'b0}}, aux_reg};
                        end
                        3'd4:
                        begin
                            dig_next[1] = quo[DIGIT_W-1:0];
                            dig_next[0] = rem[DIGIT_W-1:0];
                        end
                        default: aux_next = aux_reg;
                    endcase
                end
                else
                begin
                    case (step_reg)
                        3'd0: dig_next[0] = rem[DIGIT_W-1:0];
                        3'd1: dig_next[1] = rem[DIGIT_W-1:0];
                        3'd2: dig_next[2] = rem[DIGIT_W-1:0];
                        3'd3: dig_next[3] = rem[DIGIT_W-1:0];
                        3'd4:
                        begin
                            dig_next[4] = rem[DIGIT_W-1:0];
                            dig_next[5] = quo[DIGIT_W-1:0];
                        end
                        default: aux_next = aux_reg;
                    endcase
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = C_DONE;
                end
            end
            C_DONE:
            begin
                if (q_pop)
                begin
                    state_next = C_BUSY;
                end
                else if (fmt_take)
                begin
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
        // Loading a job overrides the datapath update.
        if (q_pop)
        begin
            step_next = '0;
            mode_next = q_entry.mode;
            val_next  = q_entry.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        mode_reg <= mode_next;
        val_reg  <= val_next;
        aux_reg  <= aux_next;
        dig_reg  <= dig_next;
    end

endmodule

/* hdl/swaf_emit.sv */
`timescale 1ns / 1ps
// Emitter: holds one converted job and sends its characters one word
// per cycle while chr_stall is low. Depends on swaf_pkg.
module swaf_emit
    import swaf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  link_t     fmt_link,
    output logic      fmt_take,
    input  fmt_t      fmt,
    output logic      chr_valid,
    input  logic      chr_stall,
    output out_word_t chr_word
);

    logic       job_valid_reg, job_valid_next;
    fmt_t       job_reg, job_next;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] last_idx;
    logic       is_last;
    logic       sent;

    assign last_idx  = (job_reg.mode == MODE_PLAIN) ? 3'd6 : 3'd7;
    assign is_last   = (idx_reg == last_idx);
    assign chr_valid = job_valid_reg;
    assign sent      = chr_valid && !chr_stall;
    assign fmt_take  = fmt_link.valid && (!job_valid_reg || (sent && is_last));

    // Character for the current position.
    always_comb
    begin
        chr_word.last     = is_last;
        chr_word.out_char = CHAR_CR;
        case (idx_reg)
            3'd0: chr_word.out_char = CHAR_CR;
            3'd1: chr_word.out_char = CHAR_ZERO + {3'b000, job_reg.digits[5]};
            3'd2: chr_word.out_char = CHAR_ZERO + {3'b000, job_reg.digits[4]};
            3'd3:
            begin
                if (job_reg.mode == MODE_MMSS)
                    chr_word.out_char = CHAR_COLON;
                else
                    chr_word.out_char = CHAR_ZERO + {3'b000, job_reg.digits[3]};
            end
            3'd4:
            begin
                if (job_reg.mode == MODE_MMSS)
                    chr_word.out_char = CHAR_ZERO + {3'b000, job_reg.digits[1]};
                else
                    chr_word.out_char = CHAR_ZERO + {3'b000, job_reg.digits[2]};
            end
            3'd5:
            begin
                if (job_reg.mode == MODE_MMSS)
                    chr_word.out_char = CHAR_ZERO + {3'b000, job_reg.digits[0]};
                else if (job_reg.mode == MODE_POINT)
                    chr_word.out_char = CHAR_POINT;
                else
                    chr_word.out_char = CHAR_ZERO + {3'b000, job_reg.digits[1]};
            end
            3'd6:
            begin
                if (job_reg.mode == MODE_MMSS)
                    chr_word.out_char = CHAR_SPACE;
                else if (job_reg.mode == MODE_POINT)
                    chr_word.out_char = CHAR_ZERO + {3'b000, job_reg.digits[1]};
                else
                    chr_word.out_char = CHAR_ZERO + {3'b000, job_reg.digits[0]};
            end
            3'd7:
            begin
                if (job_reg.mode == MODE_MMSS)
                    chr_word.out_char = CHAR_SPACE;
                else
                    chr_word.out_char = CHAR_ZERO + {3'b000, job_reg.digits[0]};
            end
            default: chr_word.out_char = CHAR_CR;
        endcase
    end

    // Position counter and job hand-over.
    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        if (sent)
        begin
            idx_next = idx_reg + 1'b1;
            if (is_last)
            begin
                job_valid_next = 1'b0;
            end
        end
        if (fmt_take)
        begin
            job_valid_next = 1'b1;
            job_next       = fmt;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

/* hdl/stopwatch_ascii_formatter.sv */
`timescale 1ns / 1ps
// Top level of the stopwatch ASCII formatter: front end, job queue,
// digit converter and character emitter. Depends on swaf_pkg.
//
//   Channel  Direction  Handshake             Word
//   req      in         req_valid/req_stall   in_word_t: command or refresh
//   chr      out        chr_valid/chr_stall   out_word_t: one character
//
// A refresh job is split into digits by the converter and then sent by the
// emitter as 8 characters (7 in plain mode), one character per cycle while
// chr_stall is low. Converter and emitter overlap on successive jobs.
// req_stall rises only while the job queue is full; reset clears mode,
// stop flag, queue and both back-end stages.
module stopwatch_ascii_formatter
    import swaf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  in_word_t  req_word,
    output logic      chr_valid,
    input  logic      chr_stall,
    output out_word_t chr_word
);

    logic  q_push;
    job_t  q_push_entry;
    logic  q_full;
    link_t q_link;
    logic  q_pop;
    job_t  q_head;
    link_t fmt_link;
    logic  fmt_take;
    fmt_t  fmt;

    // Command handling and job creation.
    swaf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .q_push    (q_push),
        .q_entry   (q_push_entry),
        .q_full    (q_full)
    );

    // Decoupling queue.
    swaf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (q_push),
        .push_entry   (q_push_entry),
        .full         (q_full),
        .pop_link_out (q_link),
        .pop          (q_pop),
        .pop_entry    (q_head)
    );

    // Digit conversion.
    swaf_conv u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_link   (q_link),
        .q_pop    (q_pop),
        .q_entry  (q_head),
        .fmt_link (fmt_link),
        .fmt_take (fmt_take),
        .fmt      (fmt)
    );

    // Character output.
    swaf_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt_link  (fmt_link),
        .fmt_take  (fmt_take),
        .fmt       (fmt),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr_word  (chr_word)
    );

endmodule

/* hdl/swaf_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the stopwatch ASCII formatter, bound to the top
// level. Depends on swaf_pkg and stopwatch_ascii_formatter.
module swaf_checker
    import swaf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_stall,
    input logic      chr_valid,
    input logic      chr_stall,
    input out_word_t chr_word
);

    logic chr_sent;

    assign chr_sent = chr_valid && !chr_stall;

    // A stalled character stays offered and unchanged.
    a_chr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && chr_stall |=> chr_valid && $stable(chr_word))
        else $error("stalled character word changed");

    // The carriage return opens a refresh and is never its final word.
    a_cr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        chr_sent && (chr_word.out_char == CHAR_CR) |-> !chr_word.last)
        else $error("carriage return marked as last");

    // A refresh ends in a decimal digit or a space.
    a_last_char: assert property (@(posedge clk) disable iff (!rst_n)
        chr_sent && chr_word.last |->
            ((chr_word.out_char >= CHAR_ZERO) && (chr_word.out_char <= CHAR_NINE)) ||
            (chr_word.out_char == CHAR_SPACE))
        else $error("unexpected final character");

    // Leaving reset, the queue is empty and nothing is offered.
    a_reset_clear: assert property (@(posedge clk)
        $rose(rst_n) |-> !req_stall && !chr_valid)
        else $error("block not clear after reset");

endmodule

bind stopwatch_ascii_formatter swaf_checker u_swaf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr_word  (chr_word)
);
